// File: rtl/smo_pkg.sv
// ----------------------------------------------------------------------------
// smo_pkg
// Shared types and constants for the spiral matrix order block.
// ----------------------------------------------------------------------------
package smo_pkg;

  localparam int IDX_W   = 3;
  localparam int DIM_W   = 4;
  localparam int COUNT_W = 7;
  localparam int OUT_W   = 32;

  // start request from the load side to the spiral sequencer
  typedef struct packed {
    logic               go;
    logic [DIM_W-1:0]   rows;
    logic [DIM_W-1:0]   cols;
    logic [COUNT_W-1:0] total;
  } smo_ctrl_t;

  // one spiral position issued to the store read port
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } smo_pos_t;

endpackage

// File: rtl/smo_ram.sv
// ----------------------------------------------------------------------------
// smo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/smo_spiral.sv
// ----------------------------------------------------------------------------
// smo_spiral
// Position sequencer: walks the four shrinking bounds one element per cycle.
// ----------------------------------------------------------------------------
module smo_spiral (
  input  logic               clk,
  input  logic               rst_n,
  input  smo_pkg::smo_ctrl_t ctrl,
  output smo_pkg::smo_pos_t  pos,
  output logic               busy
);
  import smo_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef enum logic [3:0] {
    DIR_RIGHT = 4'b0001,
    DIR_DOWN  = 4'b0010,
    DIR_LEFT  = 4'b0100,
    DIR_UP    = 4'b1000
  } dir_t;

  state_t             state_r, state_nxt;
  dir_t               dir_r, dir_nxt;
  logic [IDX_W-1:0]   row_r, row_nxt;
  logic [IDX_W-1:0]   col_r, col_nxt;
  logic [IDX_W-1:0]   top_r, top_nxt;
  logic [IDX_W-1:0]   bottom_r, bottom_nxt;
  logic [IDX_W-1:0]   left_r, left_nxt;
  logic [IDX_W-1:0]   right_r, right_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               last;

  assign last = (cnt_r == (total_r - COUNT_W'(1)));

  always_comb begin
    state_nxt  = state_r;
    dir_nxt    = dir_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    top_nxt    = top_r;
    bottom_nxt = bottom_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    cnt_nxt    = cnt_r;
    total_nxt  = total_r;
    case (state_r)
      ST_IDLE: begin
        if (ctrl.go) begin
          state_nxt  = ST_RUN;
          dir_nxt    = DIR_RIGHT;
          row_nxt    = '0;
          col_nxt    = '0;
          top_nxt    = '0;
          left_nxt   = '0;
          bottom_nxt = IDX_W'(ctrl.rows - DIM_W'(1));
          right_nxt  = IDX_W'(ctrl.cols - DIM_W'(1));
          cnt_nxt    = '0;
          total_nxt  = ctrl.total;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + COUNT_W'(1);
        if (last) begin
          state_nxt = ST_IDLE;
        end
        case (dir_r)
          DIR_RIGHT: begin
            if (col_r == right_r) begin
              dir_nxt = DIR_DOWN;
              top_nxt = top_r + IDX_W'(1);
              row_nxt = row_r + IDX_W'(1);
            end else begin
              col_nxt = col_r + IDX_W'(1);
            end
          end
          DIR_DOWN: begin
            if (row_r == bottom_r) begin
              dir_nxt   = DIR_LEFT;
              right_nxt = right_r - IDX_W'(1);
              col_nxt   = col_r - IDX_W'(1);
            end else begin
              row_nxt = row_r + IDX_W'(1);
            end
          end
          DIR_LEFT: begin
            if (col_r == left_r) begin
              dir_nxt    = DIR_UP;
              bottom_nxt = bottom_r - IDX_W'(1);
              row_nxt    = row_r - IDX_W'(1);
            end else begin
              col_nxt = col_r - IDX_W'(1);
            end
          end
          DIR_UP: begin
            if (row_r == top_r) begin
              dir_nxt  = DIR_RIGHT;
              left_nxt = left_r + IDX_W'(1);
              col_nxt  = col_r + IDX_W'(1);
            end else begin
              row_nxt = row_r - IDX_W'(1);
            end
          end
          default: begin
            dir_nxt = DIR_RIGHT;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    dir_r    <= dir_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    top_r    <= top_nxt;
    bottom_r <= bottom_nxt;
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    cnt_r    <= cnt_nxt;
    total_r  <= total_nxt;
  end

  assign busy      = (state_r == ST_RUN);
  assign pos.valid = (state_r == ST_RUN);
  assign pos.row   = row_r;
  assign pos.col   = col_r;
  assign pos.last  = last;

endmodule

// File: rtl/spiral_matrix_order.sv
// ----------------------------------------------------------------------------
// spiral_matrix_order
// Loads a matrix row-major, one item per cycle while not busy, then emits it
// in clockwise spiral order with row, column and a last-of-run flag.
// The item that completes the matrix starts the spiral sequencer; busy then
// stays high while it issues one store read per element of the matrix, and
// each result follows its store read in the next cycle.
// The receiver cannot stall: each result stands for one cycle on out_valid.
// Reset: load count cleared, both dimensions set to 8, store left as is.
// ----------------------------------------------------------------------------
module spiral_matrix_order #(
  parameter int MAX_DIM       = 8,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [31:0]        in_element_value,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [smo_pkg::DIM_W-1:0] cfg_wdata,
  output logic                      out_valid,
  output logic signed [31:0]        out_value,
  output logic [smo_pkg::IDX_W-1:0] out_row,
  output logic [smo_pkg::IDX_W-1:0] out_col,
  output logic                      out_last_of_run
);
  import smo_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] quo;
    logic [IDX_W-1:0] rem;
  } divres_t;

  // three-step restoring division, quotient below eight
  function automatic divres_t div_small(input logic [5:0] num, input logic [DIM_W-1:0] den);
    logic [6:0] rem;
    logic [6:0] sub;
    divres_t    res;
    rem     = {1'b0, num};
    res.quo = '0;
    for (int b = 2; b >= 0; b--) begin
      sub = 7'({3'b000, den} << b);
      if (rem >= sub) begin
        rem        = rem - sub;
        res.quo[b] = 1'b1;
      end
    end
    res.rem = rem[IDX_W-1:0];
    return res;
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [DIM_W-1:0]   num_rows_r, num_cols_r;
  logic [COUNT_W-1:0] load_count_r, load_count_nxt;
  logic [DIM_W-1:0]   rows_eff, cols_eff;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] lc, lc_inc;
  logic               accept;
  divres_t            wpos;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [ELEMENT_WIDTH-1:0] wdata, rdata;
  smo_ctrl_t          ctrl;
  smo_pos_t           pos;
  logic               spiral_busy;
  logic               valid_r;
  logic [IDX_W-1:0]   row_r, col_r;
  logic               last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= DIM_W'(8);
      num_cols_r <= DIM_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_ROWS: num_rows_r <= cfg_wdata;
        REG_NUM_COLS: num_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rows_eff = eff_dim(num_rows_r);
  assign cols_eff = eff_dim(num_cols_r);
  assign total    = {3'b000, rows_eff} * {3'b000, cols_eff};

  // load side
  assign accept = start && !spiral_busy;
  assign lc     = (load_count_r >= total) ? '0 : load_count_r;
  assign lc_inc = lc + COUNT_W'(1);
  assign wpos   = div_small(lc[5:0], cols_eff);
  assign waddr  = ADDR_W'(int'(wpos.quo) * MAX_DIM + int'(wpos.rem));

  always_comb begin
    load_count_nxt = load_count_r;
    if (accept) begin
      load_count_nxt = (lc_inc == total) ? '0 : lc_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
    end else begin
      load_count_r <= load_count_nxt;
    end
  end

  generate
    if (ELEMENT_WIDTH <= 32) begin : g_narrow_in
      assign wdata = in_element_value[ELEMENT_WIDTH-1:0];
    end else begin : g_wide_in
      assign wdata = {{(ELEMENT_WIDTH-32){1'b0}}, in_element_value};
    end
  endgenerate

  assign ctrl.go    = accept && (lc_inc == total);
  assign ctrl.rows  = rows_eff;
  assign ctrl.cols  = cols_eff;
  assign ctrl.total = total;

  smo_spiral u_spiral (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .pos   (pos),
    .busy  (spiral_busy)
  );

  assign raddr = ADDR_W'(int'(pos.row) * MAX_DIM + int'(pos.col));

  smo_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // position delayed to line up with the registered read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= pos.valid;
    end
    row_r  <= pos.row;
    col_r  <= pos.col;
    last_r <= pos.last;
  end

  generate
    if (ELEMENT_WIDTH >= 32) begin : g_wide_out
      assign out_value = rdata[31:0];
    end else begin : g_narrow_out
      assign out_value = {{(32-ELEMENT_WIDTH){rdata[ELEMENT_WIDTH-1]}}, rdata};
    end
  endgenerate

  assign busy            = spiral_busy;
  assign out_valid       = valid_r;
  assign out_row         = row_r;
  assign out_col         = col_r;
  assign out_last_of_run = valid_r && last_r;

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for spiral_matrix_order. Matrices are loaded through the
// command port under several dimension settings, with random gaps between
// items. A scoreboard keeps its own copy of the store and the load count,
// works out the clockwise spiral for every completed matrix and compares each
// result strobe against it, field by field, in order.
// ----------------------------------------------------------------------------

localparam int GRID_DIM = 8;

typedef struct {
  logic signed [31:0] value;
  logic [2:0]         row;
  logic [2:0]         col;
  logic               last;
} spiral_elem_t;

class spiral_scoreboard;

  logic [31:0]  grid [GRID_DIM][GRID_DIM];
  int unsigned  fill_count;
  logic [3:0]   rows_reg;
  logic [3:0]   cols_reg;
  spiral_elem_t spiral_q[$];
  int           errors;

  function new();
    fill_count = 0;
    rows_reg   = 4'd8;
    cols_reg   = 4'd8;
    errors     = 0;
  endfunction

  function int unsigned clamp_dim(logic [3:0] v);
    if (v == 0) return 1;
    if (v > GRID_DIM) return GRID_DIM;
    return 32'(v);
  endfunction

  function int unsigned matrix_size();
    return clamp_dim(rows_reg) * clamp_dim(cols_reg);
  endfunction

  function void write_reg(logic idx, logic [3:0] v);
    if (idx == 1'b0) rows_reg = v;
    else cols_reg = v;
  endfunction

  // store one element; a completed matrix queues its whole spiral
  function void note_element(logic signed [31:0] v);
    int unsigned  nr, nc, total;
    int           top, left, bottom, right, i;
    spiral_elem_t order[$];
    nr    = clamp_dim(rows_reg);
    nc    = clamp_dim(cols_reg);
    total = nr * nc;
    if (fill_count >= total) fill_count = 0;
    grid[fill_count / nc][fill_count % nc] = v;
    fill_count = (fill_count + 1) & 32'h7f;
    if (fill_count != total) return;
    fill_count = 0;
    top    = 0;
    left   = 0;
    bottom = nr;
    right  = nc;
    while (top < bottom && left < right) begin
      for (i = left; i < right; i++)
        order.push_back('{grid[top][i], 3'(top), 3'(i), 1'b0});
      top++;
      for (i = top; i < bottom; i++)
        order.push_back('{grid[i][right-1], 3'(i), 3'(right - 1), 1'b0});
      right--;
      if (top < bottom) begin
        for (i = right - 1; i >= left; i--)
          order.push_back('{grid[bottom-1][i], 3'(bottom - 1), 3'(i), 1'b0});
        bottom--;
      end
      if (left < right) begin
        for (i = bottom - 1; i >= top; i--)
          order.push_back('{grid[i][left], 3'(i), 3'(left), 1'b0});
        left++;
      end
    end
    order[order.size() - 1].last = 1'b1;
    foreach (order[k]) spiral_q.push_back(order[k]);
  endfunction

  function void check_result(logic signed [31:0] value, logic [2:0] row, logic [2:0] col,
                             logic last);
    spiral_elem_t exp_e;
    if (spiral_q.size() == 0) begin
      $error("unexpected result: value %0d row %0d col %0d", value, row, col);
      errors++;
      return;
    end
    exp_e = spiral_q.pop_front();
    if (value !== exp_e.value) begin
      $error("out_value: expected %0d, got %0d", exp_e.value, value);
      errors++;
    end
    if (row !== exp_e.row) begin
      $error("out_row: expected %0d, got %0d", exp_e.row, row);
      errors++;
    end
    if (col !== exp_e.col) begin
      $error("out_col: expected %0d, got %0d", exp_e.col, col);
      errors++;
    end
    if (last !== exp_e.last) begin
      $error("out_last_of_run: expected %0b, got %0b", exp_e.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return spiral_q.size();
  endfunction

endclass

module testbench;

  localparam logic REG_NUM_ROWS  = 1'b0;
  localparam logic REG_NUM_COLS  = 1'b1;
  localparam int   RANDOM_ITEMS  = 100;
  localparam int   SETTLE_CYCLES = 6;
  localparam int   CYCLE_LIMIT   = 200000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic signed [31:0]        in_element_value;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [smo_pkg::DIM_W-1:0] cfg_wdata;
  logic                      out_valid;
  logic signed [31:0]        out_value;
  logic [smo_pkg::IDX_W-1:0] out_row;
  logic [smo_pkg::IDX_W-1:0] out_col;
  logic                      out_last_of_run;

  int               cycle_count = 0;
  spiral_scoreboard sb = new();

  spiral_matrix_order u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_element_value(in_element_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_value       (out_value),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (start && !busy) sb.note_element(in_element_value);
      if (out_valid) sb.check_result(out_value, out_row, out_col, out_last_of_run);
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [3:0] pick_dim();
    case ($urandom_range(0, 11))
      0: return 4'd0;
      1: return 4'($urandom_range(9, 15));
      2: return 4'd8;
      default: return 4'($urandom_range(1, 5));
    endcase
  endfunction

  task automatic send_element(input logic [31:0] v);
    @(negedge clk);
    start            <= 1'b1;
    in_element_value <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic load_items(input int unsigned count, input bit no_gaps);
    for (int unsigned i = 0; i < count; i++) begin
      send_element(pick_value());
      if (!no_gaps) pause(pick_gap());
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(input logic [3:0] r, input logic [3:0] c);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NUM_ROWS;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_index <= REG_NUM_COLS;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int          n_mat;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_element_value = '0;
    cfg_we           = 1'b0;
    cfg_index        = REG_NUM_ROWS;
    cfg_wdata        = '0;
    sent             = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single-element matrices with extreme values
    set_dims(4'd1, 4'd1);
    send_element(32'h7fff_ffff);
    send_element(32'h8000_0000);
    pause(2);
    send_element(32'h0000_0000);
    send_element(32'hffff_ffff);
    settle();
    // zero dimensions act as one
    set_dims(4'd0, 4'd0);
    load_items(1, 1'b1);
    settle();
    // single row, then single column
    set_dims(4'd1, 4'd5);
    load_items(5, 1'b0);
    settle();
    set_dims(4'd4, 4'd1);
    load_items(4, 1'b1);
    settle();
    // shrink mid-load: count carries on into the smaller matrix
    set_dims(4'd3, 4'd3);
    load_items(2, 1'b0);
    settle();
    set_dims(4'd2, 4'd2);
    load_items(2, 1'b0);
    settle();
    // shrink below the count: partial load dropped
    load_items(2, 1'b1);
    settle();
    set_dims(4'd1, 4'd1);
    load_items(1, 1'b0);
    settle();

    while (sent < RANDOM_ITEMS) begin
      set_dims(pick_dim(), pick_dim());
      n_mat = $urandom_range(1, 3);
      for (int m = 0; m < n_mat; m++) begin
        load_items(sb.matrix_size(), $urandom_range(0, 3) == 0);
        sent += sb.matrix_size();
      end
      settle();
    end

    // full 8x8 at the upper extreme
    set_dims(4'd15, 4'd8);
    load_items(sb.matrix_size(), 1'b0);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
